### src/slpq_pkg.sv
package slpq_pkg;

   // Request codes
   localparam logic [1:0] REQ_SEND    = 2'd0;
   localparam logic [1:0] REQ_POLL    = 2'd1;
   localparam logic [1:0] REQ_RECYCLE = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_BAD_LEN = 2'd2;
   localparam logic [1:0] STAT_NO_SLOT = 2'd3;

   // Result field widths
   localparam int SLOT_INDEX_W  = 3;
   localparam int SLOT_LENGTH_W = 12;
   localparam int QCOUNT_W      = 4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] frame_length;
      logic [15:0] buffer_offset;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [SLOT_INDEX_W-1:0]    slot_index;
      logic [SLOT_LENGTH_W-1:0]   slot_length;
      logic [QCOUNT_W-1:0]        queued_count;
   } rsp_beat_type;

   // Operation on the slot table, at most one per cycle
   typedef enum logic [1:0] {
      SLOT_NOP,
      SLOT_ALLOC,
      SLOT_TAKE,
      SLOT_RELEASE
   } slot_op_type;

endpackage

### src/loopback_slot_pool_queue.sv
// Channel   Direction  Handshake            Beat
// req       in         req_valid/req_stall  slpq_pkg::req_beat_type
// rsp       out        rsp_valid/rsp_stall  slpq_pkg::rsp_beat_type
//
// One request at a time. Send, unused codes and a poll of an empty queue go
// straight to ST_DONE, recycle via ST_RCY_FIX (reciprocal multiply, then
// remainder correction), any other poll via ST_POLL_Q and ST_POLL_L (queue
// memory read, then length memory read); ST_DONE loads the result register.
// Reset leaves all slots free, queue empty. A stalled result holds
// in the output register; req_stall stays high until that result is loaded.
module loopback_slot_pool_queue #(
   parameter int SLOTS    = 8,
   parameter int BUF_SIZE = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  slpq_pkg::req_beat_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output slpq_pkg::rsp_beat_type  rsp_data
);
   import slpq_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int FILL_W = $clog2(SLOTS + 1);
   localparam int LEN_W  = $clog2(BUF_SIZE + 1);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUF_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POLL_Q,
      ST_POLL_L,
      ST_RCY_FIX,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   rsp_beat_type res_ff, res_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [15:0]  q_est_ff, q_est_in;
   logic [15:0]  off_ff, off_in;

   logic              accept;
   logic              push, pop;
   logic [IDX_W-1:0]  push_data;
   logic [IDX_W-1:0]  head_data;
   logic [FILL_W-1:0] fill;
   slot_op_type       slot_op;
   logic [IDX_W-1:0]  slot_idx;
   logic [LEN_W-1:0]  slot_len;
   logic [IDX_W-1:0]  rd_idx;
   logic              free_found;
   logic [IDX_W-1:0]  free_idx;
   logic              inflight_hit;
   logic [LEN_W-1:0]  len_rd;

   logic [47:0] prod;
   logic [31:0] back;
   logic [31:0] rem;
   logic [15:0] quot;

   slpq_index_fifo #(
      .SLOTS(SLOTS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .fill      (fill)
   );

   slpq_slot_table #(
      .SLOTS   (SLOTS),
      .BUF_SIZE(BUF_SIZE)
   ) u_slots (
      .clock        (clock),
      .reset        (reset),
      .op           (slot_op),
      .op_idx       (slot_idx),
      .op_len       (slot_len),
      .rd_idx       (rd_idx),
      .free_found   (free_found),
      .free_idx     (free_idx),
      .inflight_hit (inflight_hit),
      .len_rd       (len_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Offset to slot: estimate by reciprocal, then fix an estimate one low
   assign prod = 48'(req_data.buffer_offset) * 48'(RECIP);
   assign back = 32'(q_est_ff) * 32'(BUF_SIZE);
   assign rem  = 32'(off_ff) - back;
   assign quot = (rem >= 32'(BUF_SIZE)) ? q_est_ff + 16'd1 : q_est_ff;

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      q_est_in     = q_est_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      push         = 1'b0;
      push_data    = free_idx;
      pop          = 1'b0;
      slot_op      = SLOT_NOP;
      slot_idx     = free_idx;
      slot_len     = LEN_W'(req_data.frame_length);
      rd_idx       = head_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = ST_DONE;
               case (req_data.req_type)
                  REQ_SEND: begin
                     if (req_data.frame_length == 16'd0) begin
                        res_in.status = STAT_OK;
                     end else if (32'(req_data.frame_length) > 32'(BUF_SIZE)) begin
                        res_in.status = STAT_BAD_LEN;
                     end else if (!free_found || (32'(fill) >= 32'(SLOTS))) begin
                        res_in.status = STAT_NO_SLOT;
                     end else begin
                        slot_op           = SLOT_ALLOC;
                        push              = 1'b1;
                        res_in.slot_index = SLOT_INDEX_W'(free_idx);
                     end
                  end
                  REQ_POLL: begin
                     if (fill == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        pop      = 1'b1;
                        state_in = ST_POLL_Q;
                     end
                  end
                  REQ_RECYCLE: begin
                     q_est_in = prod[47:32];
                     off_in   = req_data.buffer_offset;
                     state_in = ST_RCY_FIX;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POLL_Q: begin
            // head_data holds the popped slot; start its length read
            slot_op           = SLOT_TAKE;
            slot_idx          = head_data;
            res_in.slot_index = SLOT_INDEX_W'(head_data);
            state_in          = ST_POLL_L;
         end
         ST_POLL_L: begin
            res_in.slot_length = SLOT_LENGTH_W'(len_rd);
            state_in           = ST_DONE;
         end
         ST_RCY_FIX: begin
            rd_idx = IDX_W'(quot);
            if ((32'(quot) < 32'(SLOTS)) && inflight_hit) begin
               slot_op  = SLOT_RELEASE;
               slot_idx = IDX_W'(quot);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in               = res_ff;
               rsp_data_in.queued_count  = QCOUNT_W'(fill);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      q_est_ff    <= q_est_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/slpq_index_fifo.sv
module slpq_index_fifo #(
   parameter int SLOTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [$clog2(SLOTS)-1:0]    push_data,
   input  logic                        pop,
   output logic [$clog2(SLOTS)-1:0]    head_data,
   output logic [$clog2(SLOTS+1)-1:0]  fill
);
   import slpq_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int FILL_W = $clog2(SLOTS + 1);

   logic [IDX_W-1:0]  queue_mem [SLOTS];
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  rd_ff;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_in = pop  ? wrap_inc(head_ff) : head_ff;
      tail_in = push ? wrap_inc(tail_ff) : tail_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Read the head entry every cycle; a pop captures the entry it removes
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[tail_ff] <= push_data;
      end
      rd_ff <= queue_mem[head_ff];
   end

   assign head_data = rd_ff;
   assign fill      = fill_ff;

endmodule

### src/slpq_slot_table.sv
module slpq_slot_table #(
   parameter int SLOTS    = 8,
   parameter int BUF_SIZE = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  slpq_pkg::slot_op_type            op,
   input  logic [$clog2(SLOTS)-1:0]         op_idx,
   input  logic [$clog2(BUF_SIZE+1)-1:0]    op_len,
   input  logic [$clog2(SLOTS)-1:0]         rd_idx,
   output logic                             free_found,
   output logic [$clog2(SLOTS)-1:0]         free_idx,
   output logic                             inflight_hit,
   output logic [$clog2(BUF_SIZE+1)-1:0]    len_rd
);
   import slpq_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int LEN_W = $clog2(BUF_SIZE + 1);

   logic [SLOTS-1:0] free_ff, free_in;
   logic [SLOTS-1:0] inflight_ff, inflight_in;
   logic [LEN_W-1:0] len_mem [SLOTS];
   logic [LEN_W-1:0] len_rd_ff;

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      free_in     = free_ff;
      inflight_in = inflight_ff;
      unique case (op)
         SLOT_NOP: begin
         end
         SLOT_ALLOC: begin
            free_in[op_idx] = 1'b0;
         end
         SLOT_TAKE: begin
            inflight_in[op_idx] = 1'b1;
         end
         SLOT_RELEASE: begin
            inflight_in[op_idx] = 1'b0;
            free_in[op_idx]     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff     <= '1;
         inflight_ff <= '0;
      end else begin
         free_ff     <= free_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op == SLOT_ALLOC) begin
         len_mem[op_idx] <= op_len;
      end
      len_rd_ff <= len_mem[rd_idx];
   end

   assign inflight_hit = inflight_ff[rd_idx];
   assign len_rd       = len_rd_ff;

endmodule
